@@ rtl/cft_pkg.sv @@
package cft_pkg;

    localparam int LINE_BITS_DEF = 16;
    localparam int LINE_OUT_W    = 16;
    localparam int MAX_RES       = 3;

    // Lexer modes, one-hot.
    typedef enum logic [5:0] {
        MODE_NORMAL  = 6'b000001,
        MODE_WORD    = 6'b000010,
        MODE_ESC     = 6'b000100,
        MODE_QUOTE   = 6'b001000,
        MODE_COMMENT = 6'b010000,
        MODE_HALT    = 6'b100000
    } mode_t;

    typedef enum logic [2:0] {
        EV_TEXT    = 3'd0,
        EV_DONE    = 3'd1,
        EV_OPEN    = 3'd2,
        EV_CLOSE   = 3'd3,
        EV_SEMI    = 3'd4,
        EV_UNKNOWN = 3'd5,
        EV_EOF     = 3'd6,
        EV_UNTERM  = 3'd7
    } event_t;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOI  = 1'b1;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_OPEN    = 8'h7B;
    localparam logic [7:0] CH_CLOSE   = 8'h7D;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_PRT_LO  = 8'h20;
    localparam logic [7:0] CH_PRT_HI  = 8'h7E;

    typedef struct packed {
        event_t     ev;
        logic [7:0] data;
    } res_t;

    // All results caused by one input word.
    typedef struct packed {
        logic [1:0]   cnt;
        res_t [2:0]   res;
    } group_t;

    typedef struct packed {
        mode_t  mode;
        logic   line_inc;
        logic   line_clr;
        group_t grp;
    } lex_out_t;

endpackage

@@ rtl/cft_lex.sv @@
module cft_lex (
    input  logic              kind,
    input  logic [7:0]        data_byte,
    input  cft_pkg::mode_t    mode,
    output cft_pkg::lex_out_t lex
);

    // Outcome of a byte seen between tokens: at most two results.
    typedef struct packed {
        cft_pkg::mode_t      mode;
        logic                inc;
        logic [1:0]          cnt;
        cft_pkg::res_t [1:0] res;
    } bt_t;

    function automatic cft_pkg::res_t mk(input cft_pkg::event_t ev, input logic [7:0] b);
        cft_pkg::res_t r;
        r.ev   = ev;
        r.data = b;
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {cft_pkg::CH_SPACE, [cft_pkg::CH_TAB:cft_pkg::CH_CR]};
    endfunction

    function automatic bt_t between(input logic [7:0] c);
        bt_t r;
        r.mode = cft_pkg::MODE_NORMAL;
        r.inc  = 1'b0;
        r.cnt  = 2'd0;
        r.res  = '0;
        if (c == cft_pkg::CH_NL) begin
            r.inc = 1'b1;
        end else if (is_space(c)) begin
            r.cnt = 2'd0;
        end else if (c == cft_pkg::CH_HASH) begin
            r.mode = cft_pkg::MODE_COMMENT;
        end else if (c == cft_pkg::CH_OPEN) begin
            r.cnt    = 2'd1;
            r.res[0] = mk(cft_pkg::EV_OPEN, c);
        end else if (c == cft_pkg::CH_CLOSE) begin
            r.cnt    = 2'd1;
            r.res[0] = mk(cft_pkg::EV_CLOSE, c);
        end else if (c == cft_pkg::CH_SEMI) begin
            r.cnt    = 2'd1;
            r.res[0] = mk(cft_pkg::EV_SEMI, c);
        end else if (c == cft_pkg::CH_QUOTE) begin
            r.mode = cft_pkg::MODE_QUOTE;
        end else if (!(c inside {[cft_pkg::CH_PRT_LO:cft_pkg::CH_PRT_HI]})) begin
            // A non-printable token start ends the stream for good.
            r.cnt    = 2'd2;
            r.res[0] = mk(cft_pkg::EV_UNKNOWN, c);
            r.res[1] = mk(cft_pkg::EV_EOF, 8'd0);
            r.mode   = cft_pkg::MODE_HALT;
        end else if (c == cft_pkg::CH_BSLASH) begin
            r.mode = cft_pkg::MODE_ESC;
        end else begin
            r.cnt    = 2'd1;
            r.res[0] = mk(cft_pkg::EV_TEXT, c);
            r.mode   = cft_pkg::MODE_WORD;
        end
        return r;
    endfunction

    bt_t  bt;
    logic word_end;

    assign bt       = between(data_byte);
    assign word_end = is_space(data_byte) || data_byte == cft_pkg::CH_OPEN
                   || data_byte == cft_pkg::CH_CLOSE || data_byte == cft_pkg::CH_SEMI
                   || data_byte == cft_pkg::CH_QUOTE;

    always_comb begin
        lex.mode     = mode;
        lex.line_inc = 1'b0;
        lex.line_clr = 1'b0;
        lex.grp      = '0;
        if (kind == cft_pkg::KIND_EOI) begin
            case (mode)
                cft_pkg::MODE_NORMAL, cft_pkg::MODE_COMMENT: begin
                    lex.grp.cnt    = 2'd1;
                    lex.grp.res[0] = mk(cft_pkg::EV_EOF, 8'd0);
                    lex.mode       = cft_pkg::MODE_NORMAL;
                    lex.line_clr   = 1'b1;
                end
                cft_pkg::MODE_ESC: begin
                    lex.grp.cnt    = 2'd3;
                    lex.grp.res[0] = mk(cft_pkg::EV_TEXT, cft_pkg::CH_BSLASH);
                    lex.grp.res[1] = mk(cft_pkg::EV_DONE, 8'd0);
                    lex.grp.res[2] = mk(cft_pkg::EV_EOF, 8'd0);
                    lex.mode       = cft_pkg::MODE_NORMAL;
                    lex.line_clr   = 1'b1;
                end
                cft_pkg::MODE_WORD: begin
                    lex.grp.cnt    = 2'd2;
                    lex.grp.res[0] = mk(cft_pkg::EV_DONE, 8'd0);
                    lex.grp.res[1] = mk(cft_pkg::EV_EOF, 8'd0);
                    lex.mode       = cft_pkg::MODE_NORMAL;
                    lex.line_clr   = 1'b1;
                end
                cft_pkg::MODE_QUOTE: begin
                    lex.grp.cnt    = 2'd2;
                    lex.grp.res[0] = mk(cft_pkg::EV_DONE, 8'd0);
                    lex.grp.res[1] = mk(cft_pkg::EV_UNTERM, 8'd0);
                    lex.mode       = cft_pkg::MODE_HALT;
                end
                default: begin
                    lex.mode = mode;
                end
            endcase
        end else begin
            case (mode)
                cft_pkg::MODE_NORMAL: begin
                    lex.grp.cnt    = bt.cnt;
                    lex.grp.res[0] = bt.res[0];
                    lex.grp.res[1] = bt.res[1];
                    lex.mode       = bt.mode;
                    lex.line_inc   = bt.inc;
                end
                cft_pkg::MODE_WORD: begin
                    if (word_end) begin
                        // The terminator is lexed again as if between tokens.
                        lex.grp.cnt    = 2'd1 + bt.cnt;
                        lex.grp.res[0] = mk(cft_pkg::EV_DONE, 8'd0);
                        lex.grp.res[1] = bt.res[0];
                        lex.grp.res[2] = bt.res[1];
                        lex.mode       = bt.mode;
                        lex.line_inc   = bt.inc;
                    end else if (data_byte == cft_pkg::CH_BSLASH) begin
                        lex.mode = cft_pkg::MODE_ESC;
                    end else begin
                        lex.grp.cnt    = 2'd1;
                        lex.grp.res[0] = mk(cft_pkg::EV_TEXT, data_byte);
                    end
                end
                cft_pkg::MODE_ESC: begin
                    lex.grp.cnt    = 2'd1;
                    lex.grp.res[0] = mk(cft_pkg::EV_TEXT, data_byte);
                    lex.mode       = cft_pkg::MODE_WORD;
                end
                cft_pkg::MODE_QUOTE: begin
                    lex.grp.cnt = 2'd1;
                    if (data_byte == cft_pkg::CH_QUOTE) begin
                        lex.grp.res[0] = mk(cft_pkg::EV_DONE, 8'd0);
                        lex.mode       = cft_pkg::MODE_NORMAL;
                    end else begin
                        lex.grp.res[0] = mk(cft_pkg::EV_TEXT, data_byte);
                    end
                end
                cft_pkg::MODE_COMMENT: begin
                    if (data_byte == cft_pkg::CH_NL) begin
                        lex.line_inc = 1'b1;
                        lex.mode     = cft_pkg::MODE_NORMAL;
                    end
                end
                default: begin
                    lex.mode = mode;
                end
            endcase
        end
    end

endmodule

@@ rtl/config_file_tokenizer_core.sv @@
// Channel   Direction  Ports
// s_        in         s_valid, s_ready, s_kind, s_data_byte
// m_        out        m_valid, m_ready, m_event_res, m_out_byte, m_line_number, m_last
//
// A byte is lexed in the cycle it is accepted; its results are held in a
// three-entry result group and leave one word per cycle while m_ready is high,
// starting the next cycle. An input causing n results (zero to three) holds the
// output until all are taken; the next input is taken in the cycle the last is taken.
// aresetn is synchronous, active low; it resets the mode and group and the line count to 1.
// A stalled output holds the group, and s_ready stays low until its final word goes.
module config_file_tokenizer_core #(
    parameter int LINE_BITS = cft_pkg::LINE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [7:0]  m_out_byte,
    output logic [15:0] m_line_number,
    output logic        m_last
);

    cft_pkg::mode_t    mode_reg, mode_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [15:0]       grp_line_reg;
    cft_pkg::res_t [2:0] res_reg;
    logic [1:0]        cnt_reg, cnt_next;
    logic [1:0]        idx_reg, idx_next;
    cft_pkg::lex_out_t lex;
    logic              s_acc;
    logic              at_last;
    logic [LINE_BITS+15:0] line_ext;

    cft_lex u_lex (
        .kind      (s_kind),
        .data_byte (s_data_byte),
        .mode      (mode_reg),
        .lex       (lex)
    );

    assign m_valid = idx_reg != cnt_reg;
    assign at_last = idx_reg == cnt_reg - 2'd1;
    assign s_ready = !m_valid || (at_last && m_ready);
    assign s_acc   = s_valid && s_ready;
    assign line_ext = {16'd0, line_reg};

    assign m_event_res   = res_reg[idx_reg].ev;
    assign m_out_byte    = res_reg[idx_reg].data;
    assign m_line_number = grp_line_reg;
    assign m_last        = at_last;

    always_comb begin
        mode_next = mode_reg;
        line_next = line_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        if (s_acc) begin
            mode_next = lex.mode;
            cnt_next  = lex.grp.cnt;
            idx_next  = 2'd0;
            if (lex.line_clr) begin
                line_next = LINE_BITS'(1);
            end else if (lex.line_inc && line_reg != '1) begin
                line_next = line_reg + LINE_BITS'(1);
            end
        end else if (m_valid && m_ready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= cft_pkg::MODE_NORMAL;
            line_reg <= LINE_BITS'(1);
            cnt_reg  <= 2'd0;
            idx_reg  <= 2'd0;
        end else begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            cnt_reg  <= cnt_next;
            idx_reg  <= idx_next;
        end
    end

    // Every result of one input carries the line count from before that input.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            res_reg      <= lex.grp.res;
            grp_line_reg <= line_ext[15:0];
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= cnt_reg)
        else $error("result index ran past the group");

    a_mode_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(mode_reg))
        else $error("lexer mode is not one-hot");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == cft_pkg::MODE_HALT |=> mode_reg == cft_pkg::MODE_HALT)
        else $error("lexer left the halted mode without reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no pending result");

    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg != '0)
        else $error("line count reached zero");
`endif

endmodule

@@ verif/config_file_tokenizer_core_tb.sv @@
module config_file_tokenizer_core_tb;

    localparam int IDLE_PCT     = 26;
    localparam int STALL_LIMIT  = 5000;
    localparam int RAND_WORDS   = 440;
    localparam int LINE_STEPS   = 6;
    localparam int MAX_PRINTS   = 100;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        cft_pkg::event_t ev;
        logic [7:0]      ob;
        logic [15:0]     ln;
        logic            last;
    } tok_t;

    typedef struct packed {
        logic            kind;
        logic [7:0]      ch;
        logic            typed;
        cft_pkg::group_t grp;
        logic [15:0]     ln;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_kind = cft_pkg::KIND_DATA;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [2:0]  m_event_res;
    logic [7:0]  m_out_byte;
    logic [15:0] m_line_number;
    logic        m_last;

    // Predictor state.
    cft_pkg::mode_t lex_mode = cft_pkg::MODE_NORMAL;
    logic [15:0]    line_cnt = 16'd1;
    tok_t           pending_tokens[$];

    row_t dir_tab[$];

    int errors = 0;
    int n_in = 0;
    int n_out = 0;
    int stall_cycles = 0;
    bit idle_on = 1'b1;

    logic        mon_s_fire = 1'b0;
    logic        mon_m_fire = 1'b0;
    logic [2:0]  mon_ev;
    logic [7:0]  mon_ob;
    logic [15:0] mon_ln;
    logic        mon_last;

    config_file_tokenizer_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_res   (m_event_res),
        .m_out_byte    (m_out_byte),
        .m_line_number (m_line_number),
        .m_last        (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit is_ws(logic [7:0] c);
        return c == cft_pkg::CH_SPACE || (c >= cft_pkg::CH_TAB && c <= cft_pkg::CH_CR);
    endfunction

    function automatic bit is_sep(logic [7:0] c);
        return is_ws(c) || c == cft_pkg::CH_OPEN || c == cft_pkg::CH_CLOSE
            || c == cft_pkg::CH_SEMI || c == cft_pkg::CH_QUOTE;
    endfunction

    function automatic bit is_printable(logic [7:0] c);
        return c >= cft_pkg::CH_PRT_LO && c <= cft_pkg::CH_PRT_HI;
    endfunction

    function automatic void append_tok(tok_t t);
        pending_tokens.insert(pending_tokens.size(), t);
    endfunction

    function automatic void add_row(row_t r);
        dir_tab.insert(dir_tab.size(), r);
    endfunction

    function automatic void add_tok(cft_pkg::event_t ev, logic [7:0] b);
        tok_t t;
        t = '{ev, b, line_cnt, 1'b0};
        append_tok(t);
    endfunction

    function automatic void next_line();
        if (line_cnt != 16'hFFFF) line_cnt = line_cnt + 16'd1;
    endfunction

    function automatic void lex_between(logic [7:0] c);
        if (c == cft_pkg::CH_NL) begin
            next_line();
        end else if (is_ws(c)) begin
        end else if (c == cft_pkg::CH_HASH) begin
            lex_mode = cft_pkg::MODE_COMMENT;
        end else if (c == cft_pkg::CH_OPEN) begin
            add_tok(cft_pkg::EV_OPEN, c);
        end else if (c == cft_pkg::CH_CLOSE) begin
            add_tok(cft_pkg::EV_CLOSE, c);
        end else if (c == cft_pkg::CH_SEMI) begin
            add_tok(cft_pkg::EV_SEMI, c);
        end else if (c == cft_pkg::CH_QUOTE) begin
            lex_mode = cft_pkg::MODE_QUOTE;
        end else if (!is_printable(c)) begin
            add_tok(cft_pkg::EV_UNKNOWN, c);
            add_tok(cft_pkg::EV_EOF, 8'h00);
            lex_mode = cft_pkg::MODE_HALT;
        end else if (c == cft_pkg::CH_BSLASH) begin
            lex_mode = cft_pkg::MODE_ESC;
        end else begin
            add_tok(cft_pkg::EV_TEXT, c);
            lex_mode = cft_pkg::MODE_WORD;
        end
    endfunction

    // Works out the results of one input word and appends them.
    function automatic void lex_byte(logic k, logic [7:0] c);
        int base;
        base = pending_tokens.size();
        if (k == cft_pkg::KIND_EOI) begin
            case (lex_mode)
                cft_pkg::MODE_NORMAL, cft_pkg::MODE_COMMENT: begin
                    add_tok(cft_pkg::EV_EOF, 8'h00);
                    lex_mode = cft_pkg::MODE_NORMAL;
                    line_cnt = 16'd1;
                end
                cft_pkg::MODE_ESC, cft_pkg::MODE_WORD: begin
                    if (lex_mode == cft_pkg::MODE_ESC) add_tok(cft_pkg::EV_TEXT, cft_pkg::CH_BSLASH);
                    add_tok(cft_pkg::EV_DONE, 8'h00);
                    add_tok(cft_pkg::EV_EOF, 8'h00);
                    lex_mode = cft_pkg::MODE_NORMAL;
                    line_cnt = 16'd1;
                end
                cft_pkg::MODE_QUOTE: begin
                    add_tok(cft_pkg::EV_DONE, 8'h00);
                    add_tok(cft_pkg::EV_UNTERM, 8'h00);
                    lex_mode = cft_pkg::MODE_HALT;
                end
                default: begin
                end
            endcase
        end else begin
            case (lex_mode)
                cft_pkg::MODE_NORMAL: begin
                    lex_between(c);
                end
                cft_pkg::MODE_WORD: begin
                    if (is_sep(c)) begin
                        add_tok(cft_pkg::EV_DONE, 8'h00);
                        lex_mode = cft_pkg::MODE_NORMAL;
                        lex_between(c);
                    end else if (c == cft_pkg::CH_BSLASH) begin
                        lex_mode = cft_pkg::MODE_ESC;
                    end else begin
                        add_tok(cft_pkg::EV_TEXT, c);
                    end
                end
                cft_pkg::MODE_ESC: begin
                    add_tok(cft_pkg::EV_TEXT, c);
                    lex_mode = cft_pkg::MODE_WORD;
                end
                cft_pkg::MODE_QUOTE: begin
                    if (c == cft_pkg::CH_QUOTE) begin
                        add_tok(cft_pkg::EV_DONE, 8'h00);
                        lex_mode = cft_pkg::MODE_NORMAL;
                    end else begin
                        add_tok(cft_pkg::EV_TEXT, c);
                    end
                end
                cft_pkg::MODE_COMMENT: begin
                    if (c == cft_pkg::CH_NL) begin
                        next_line();
                        lex_mode = cft_pkg::MODE_NORMAL;
                    end
                end
                default: begin
                end
            endcase
        end
        if (pending_tokens.size() > base)
            pending_tokens[pending_tokens.size() - 1].last = 1'b1;
    endfunction

    function automatic row_t row(logic k, logic [7:0] c, bit typed = 1'b0, int cnt = 0,
                                 cft_pkg::event_t e0 = cft_pkg::EV_TEXT,
                                 logic [7:0] b0 = 8'h00,
                                 cft_pkg::event_t e1 = cft_pkg::EV_TEXT,
                                 logic [7:0] b1 = 8'h00,
                                 cft_pkg::event_t e2 = cft_pkg::EV_TEXT,
                                 logic [7:0] b2 = 8'h00,
                                 logic [15:0] ln = 16'd1);
        row_t r;
        r.kind = k;
        r.ch = c;
        r.typed = typed;
        r.grp.cnt = cnt[1:0];
        r.grp.res[0] = '{e0, b0};
        r.grp.res[1] = '{e1, b1};
        r.grp.res[2] = '{e2, b2};
        r.ln = ln;
        return r;
    endfunction

    function automatic logic [7:0] rand_word_char(bit first);
        logic [7:0] c;
        bit printable;
        printable = first || $urandom_range(0, 99) < 70;
        do begin
            c = printable ? 8'($urandom_range(33, 126)) : 8'($urandom_range(0, 255));
        end while (is_sep(c) || c == cft_pkg::CH_BSLASH || (first && c == cft_pkg::CH_HASH));
        return c;
    endfunction

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic drive_word(input logic k, input logic [7:0] c);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= k;
        s_data_byte <= c;
        // Ready is looked at mid-cycle so the accepting edge is known race free.
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        n_in++;
    endtask

    // Keeps the stream from halting unless the caller wants it to.
    task automatic send_word(input logic k, input logic [7:0] c, input bit allow_halt = 1'b0);
        logic       kk;
        logic [7:0] cc;
        kk = k;
        cc = c;
        if (!allow_halt) begin
            if (kk == cft_pkg::KIND_EOI && lex_mode == cft_pkg::MODE_QUOTE) begin
                kk = cft_pkg::KIND_DATA;
                cc = cft_pkg::CH_QUOTE;
            end else if (kk == cft_pkg::KIND_DATA && lex_mode == cft_pkg::MODE_NORMAL
                         && !is_ws(cc) && !is_printable(cc)) begin
                cc = cft_pkg::CH_SPACE;
            end
        end
        lex_byte(kk, cc);
        drive_word(kk, cc);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_tokens.size() != 0);
    endtask

    always @(negedge aclk) begin
        mon_s_fire <= aresetn && s_valid && s_ready;
        mon_m_fire <= aresetn && m_valid && m_ready;
        mon_ev <= m_event_res;
        mon_ob <= m_out_byte;
        mon_ln <= m_line_number;
        mon_last <= m_last;
    end

    always @(posedge aclk) begin : result_check
        tok_t want;
        m_ready <= !idle_on || $urandom_range(0, 99) >= IDLE_PCT;
        if (mon_m_fire) begin
            n_out++;
            if (pending_tokens.size() == 0) begin
                report("result word with nothing expected", {13'd0, mon_ev}, 16'd0);
            end else begin
                want = pending_tokens.pop_front();
                if (mon_ev !== want.ev) report("event_res", {13'd0, mon_ev}, {13'd0, want.ev});
                if (mon_ob !== want.ob) report("out_byte", {8'd0, mon_ob}, {8'd0, want.ob});
                if (mon_ln !== want.ln) report("line_number", mon_ln, want.ln);
                if (mon_last !== want.last) report("last", {15'd0, mon_last}, {15'd0, want.last});
            end
        end
        if (mon_s_fire || mon_m_fire) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_tokens.size());
            $display("config_file_tokenizer_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        tok_t       t;
        int         base, cnt, r, len, start, last_pause;
        bit         ending;
        logic [7:0] c;
        logic [7:0] term_ch[8];

        term_ch = '{cft_pkg::CH_SPACE, cft_pkg::CH_TAB, cft_pkg::CH_NL, cft_pkg::CH_CR,
                    cft_pkg::CH_OPEN, cft_pkg::CH_CLOSE, cft_pkg::CH_SEMI, cft_pkg::CH_QUOTE};

        // Directed stream: typed rows are the obvious ones, the rest go through the predictor.
        add_row(row(cft_pkg::KIND_EOI, 8'h5A, 1'b1, 1, cft_pkg::EV_EOF, 8'h00));
        add_row(row(cft_pkg::KIND_DATA, cft_pkg::CH_OPEN, 1'b1, 1,
                    cft_pkg::EV_OPEN, cft_pkg::CH_OPEN));
        add_row(row(cft_pkg::KIND_DATA, cft_pkg::CH_CLOSE, 1'b1, 1,
                    cft_pkg::EV_CLOSE, cft_pkg::CH_CLOSE));
        add_row(row(cft_pkg::KIND_DATA, cft_pkg::CH_SEMI, 1'b1, 1,
                    cft_pkg::EV_SEMI, cft_pkg::CH_SEMI));
        add_row(row(cft_pkg::KIND_DATA, cft_pkg::CH_PRT_HI));
        add_row(row(cft_pkg::KIND_DATA, 8'h00));
        add_row(row(cft_pkg::KIND_DATA, 8'hFF));
        add_row(row(cft_pkg::KIND_DATA, cft_pkg::CH_BSLASH));
        add_row(row(cft_pkg::KIND_DATA, cft_pkg::CH_NL));
        add_row(row(cft_pkg::KIND_DATA, cft_pkg::CH_SEMI));
        add_row(row(cft_pkg::KIND_DATA, cft_pkg::CH_QUOTE));
        add_row(row(cft_pkg::KIND_DATA, 8'h80));
        add_row(row(cft_pkg::KIND_DATA, cft_pkg::CH_NL));
        add_row(row(cft_pkg::KIND_DATA, cft_pkg::CH_BSLASH));
        add_row(row(cft_pkg::KIND_DATA, cft_pkg::CH_QUOTE));
        add_row(row(cft_pkg::KIND_DATA, cft_pkg::CH_HASH));
        add_row(row(cft_pkg::KIND_DATA, 8'h7F));
        add_row(row(cft_pkg::KIND_DATA, cft_pkg::CH_NL));
        add_row(row(cft_pkg::KIND_DATA, cft_pkg::CH_BSLASH));
        add_row(row(cft_pkg::KIND_EOI, 8'hA5, 1'b1, 3,
                    cft_pkg::EV_TEXT, cft_pkg::CH_BSLASH, cft_pkg::EV_DONE, 8'h00,
                    cft_pkg::EV_EOF, 8'h00, 16'd2));
        add_row(row(cft_pkg::KIND_DATA, 8'h21));
        add_row(row(cft_pkg::KIND_DATA, cft_pkg::CH_CR));
        add_row(row(cft_pkg::KIND_DATA, 8'h71));
        add_row(row(cft_pkg::KIND_EOI, 8'hFF, 1'b1, 2,
                    cft_pkg::EV_DONE, 8'h00, cft_pkg::EV_EOF, 8'h00));
        add_row(row(cft_pkg::KIND_DATA, cft_pkg::CH_HASH, 1'b1, 0));
        add_row(row(cft_pkg::KIND_EOI, 8'h00, 1'b1, 1, cft_pkg::EV_EOF, 8'h00));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            base = pending_tokens.size();
            lex_byte(dir_tab[i].kind, dir_tab[i].ch);
            if (dir_tab[i].typed) begin
                while (pending_tokens.size() > base) void'(pending_tokens.pop_back());
                cnt = dir_tab[i].grp.cnt;
                for (int j = 0; j < cnt; j++) begin
                    t = '{dir_tab[i].grp.res[j].ev, dir_tab[i].grp.res[j].data,
                          dir_tab[i].ln, j == cnt - 1};
                    append_tok(t);
                end
            end
            drive_word(dir_tab[i].kind, dir_tab[i].ch);
        end

        // Walk the line count up a few lines, show it on a word and clear it.
        repeat (LINE_STEPS) send_word(cft_pkg::KIND_DATA, cft_pkg::CH_NL);
        send_word(cft_pkg::KIND_DATA, 8'h77);
        send_word(cft_pkg::KIND_DATA, cft_pkg::CH_SPACE);
        send_word(cft_pkg::KIND_DATA, cft_pkg::CH_NL);
        send_word(cft_pkg::KIND_DATA, cft_pkg::CH_SEMI);
        send_word(cft_pkg::KIND_EOI, 8'h00);
        hold_until_drained();

        start = n_in;
        last_pause = n_in;
        while (n_in - start < RAND_WORDS) begin
            idle_on = !(n_in - start >= 150 && n_in - start < 300);
            if (n_in - last_pause >= 125) begin
                hold_until_drained();
                last_pause = n_in;
            end
            r = $urandom_range(0, 99);
            if (r < 30) begin
                if ($urandom_range(0, 9) < 2) begin
                    send_word(cft_pkg::KIND_DATA, cft_pkg::CH_BSLASH);
                    send_word(cft_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
                end else begin
                    send_word(cft_pkg::KIND_DATA, rand_word_char(1'b1));
                end
                len = $urandom_range(0, 7);
                for (int j = 0; j < len; j++) begin
                    if ($urandom_range(0, 99) < 15) begin
                        send_word(cft_pkg::KIND_DATA, cft_pkg::CH_BSLASH);
                        send_word(cft_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
                    end else begin
                        send_word(cft_pkg::KIND_DATA, rand_word_char(1'b0));
                    end
                end
                send_word(cft_pkg::KIND_DATA, term_ch[3'($urandom_range(0, 7))]);
            end else if (r < 45) begin
                send_word(cft_pkg::KIND_DATA, cft_pkg::CH_QUOTE);
                len = $urandom_range(0, 8);
                for (int j = 0; j < len; j++) begin
                    do c = 8'($urandom_range(0, 255)); while (c == cft_pkg::CH_QUOTE);
                    if ($urandom_range(0, 9) == 0) c = cft_pkg::CH_NL;
                    send_word(cft_pkg::KIND_DATA, c);
                end
                send_word(cft_pkg::KIND_DATA, cft_pkg::CH_QUOTE);
            end else if (r < 55) begin
                send_word(cft_pkg::KIND_DATA, cft_pkg::CH_HASH);
                len = $urandom_range(0, 6);
                for (int j = 0; j < len; j++) begin
                    do c = 8'($urandom_range(0, 255)); while (c == cft_pkg::CH_NL);
                    send_word(cft_pkg::KIND_DATA, c);
                end
                send_word(cft_pkg::KIND_DATA, cft_pkg::CH_NL);
            end else if (r < 75) begin
                send_word(cft_pkg::KIND_DATA, term_ch[3'($urandom_range(4, 6))]);
            end else if (r < 88) begin
                c = $urandom_range(0, 1) ? cft_pkg::CH_NL : 8'($urandom_range(9, 13));
                send_word(cft_pkg::KIND_DATA, $urandom_range(0, 3) == 0 ? cft_pkg::CH_SPACE : c);
            end else if (r < 93) begin
                send_word(cft_pkg::KIND_EOI, 8'($urandom_range(0, 255)));
            end else begin
                send_word($urandom_range(0, 7) == 0 ? cft_pkg::KIND_EOI : cft_pkg::KIND_DATA,
                          8'($urandom_range(0, 255)));
            end
        end
        idle_on = 1'b1;

        // Only one halt is possible per reset, so the seed picks which one ends the stream.
        while (lex_mode != cft_pkg::MODE_NORMAL)
            send_word(cft_pkg::KIND_EOI, 8'($urandom_range(0, 255)));
        hold_until_drained();
        ending = 1'($urandom_range(0, 1));
        if (ending) begin
            send_word(cft_pkg::KIND_DATA, cft_pkg::CH_QUOTE);
            do c = 8'($urandom_range(0, 255)); while (c == cft_pkg::CH_QUOTE);
            send_word(cft_pkg::KIND_DATA, c);
            send_word(cft_pkg::KIND_EOI, 8'($urandom_range(0, 255)), 1'b1);
        end else begin
            do c = 8'($urandom_range(0, 255)); while (is_ws(c) || is_printable(c));
            send_word(cft_pkg::KIND_DATA, c, 1'b1);
        end
        // Once halted, nothing comes out whatever is sent.
        repeat (8) send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1);

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("summary: %0d input words, %0d result words checked, %0d mismatches",
                 n_in, n_out, errors);
        $display("summary: directed table, line walk and random mix sent; halted by %s",
                 ending ? "an unterminated quote" : "a non-printable token start");
        if (errors == 0) begin
            $display("config_file_tokenizer_core_tb: done, clean");
        end else begin
            $display("config_file_tokenizer_core_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/cft_pkg.sv
rtl/cft_lex.sv
rtl/config_file_tokenizer_core.sv
verif/config_file_tokenizer_core_tb.sv
